// ===== rtl/tbts_pkg.sv =====
// Package for the Thumb block-transfer sequencer.
// Holds opcodes, register numbers, store source codes and the
// controller/datapath interface types. No dependencies.
package tbts_pkg;

  localparam logic [1:0] OP_STMIA = 2'd0;
  localparam logic [1:0] OP_LDMIA = 2'd1;
  localparam logic [1:0] OP_PUSH  = 2'd2;
  localparam logic [1:0] OP_POP   = 2'd3;

  localparam logic [3:0] SP_INDEX = 4'd13;
  localparam logic [3:0] LR_INDEX = 4'd14;
  localparam logic [3:0] PC_INDEX = 4'd15;

  localparam logic [1:0] SRC_REG      = 2'd0;
  localparam logic [1:0] SRC_FINAL    = 2'd1;
  localparam logic [1:0] SRC_PC_PLUS2 = 2'd2;

  localparam logic [31:0] EMPTY_STEP = 32'h0000_0040;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;  // capture a new instruction
    logic step;  // emit the next transfer into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;  // the transfer about to be emitted ends the instruction
  } status_t;

endpackage

// ===== rtl/tbts_ctrl.sv =====
// Controller of the Thumb block-transfer sequencer.
// Sequences one instruction at a time and owns the output valid flag.
// Depends on tbts_pkg.
module tbts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tbts_pkg::cmd_t    cmd_o,
  input  tbts_pkg::status_t status_i
);
  import tbts_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (out_free && status_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.step = out_free;
      end
      default: ;
    endcase
  end

  // Hold the result until the transfer on the output side completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/tbts_datapath.sv =====
// Datapath of the Thumb block-transfer sequencer.
// Holds the instruction, walks the register list and drives the result register.
// Depends on tbts_pkg.
module tbts_datapath (
  input  logic              clk_i,
  input  tbts_pkg::cmd_t    cmd_i,
  output tbts_pkg::status_t status_o,
  input  logic [1:0]        op_i,
  input  logic [7:0]        reg_list_i,
  input  logic [2:0]        base_index_i,
  input  logic [31:0]       base_value_i,
  input  logic              with_link_or_pc_i,
  output logic              transfer_valid_o,
  output logic [31:0]       address_o,
  output logic [3:0]        reg_index_o,
  output logic              is_load_o,
  output logic [1:0]        store_source_o,
  output logic              clear_low_bit_o,
  output logic              flush_pipeline_o,
  output logic [3:0]        writeback_index_o,
  output logic [31:0]       writeback_value_o,
  output logic              last_o
);
  import tbts_pkg::*;

  // Instruction state.
  logic [7:0]  list_q, list_d;
  logic        extra_q, extra_d;   // one more transfer to PC or LR after the list
  logic        lsm_q, lsm_d;       // load or store multiple
  logic        load_q, load_d;
  logic        first_q, first_d;
  logic [2:0]  bidx_q, bidx_d;
  logic [3:0]  wb_idx_q, wb_idx_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] final_q, final_d;

  // Result register.
  logic        tv_q, tv_d;
  logic [31:0] address_q, address_d;
  logic [3:0]  reg_q, reg_d;
  logic        ld_q, ld_d;
  logic [1:0]  src_q, src_d;
  logic        clr_q, clr_d;
  logic        flush_q, flush_d;
  logic [3:0]  wbi_q, wbi_d;
  logic [31:0] wbv_q, wbv_d;
  logic        last_q, last_d;

  logic [3:0]  count;
  logic [3:0]  words;
  logic [31:0] span;
  logic        in_lsm;
  logic [2:0]  low_idx;
  logic [7:0]  list_rest;
  logic        step_last;

  // Setup of a new instruction.
  always_comb begin
    count = 4'd0;
    for (int i = 0; i < 8; i++) begin
      count = count + 4'(reg_list_i[i]);
    end
    in_lsm = (op_i == OP_STMIA) || (op_i == OP_LDMIA);
    words  = count + 4'(with_link_or_pc_i && !in_lsm);
    span   = {26'd0, words, 2'b00};
  end

  // Lowest listed register still pending.
  always_comb begin
    low_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (list_q[i]) low_idx = 3'(i);
    end
    list_rest = list_q & (list_q - 8'd1);
    if (list_q != 8'd0) begin
      step_last = (list_rest == 8'd0) && !extra_q;
    end else begin
      step_last = 1'b1;
    end
  end

  assign status_o.last = step_last;

  always_comb begin
    list_d   = list_q;
    extra_d  = extra_q;
    lsm_d    = lsm_q;
    load_d   = load_q;
    first_d  = first_q;
    bidx_d   = bidx_q;
    wb_idx_d = wb_idx_q;
    addr_d   = addr_q;
    final_d  = final_q;

    tv_d      = tv_q;
    address_d = address_q;
    reg_d     = reg_q;
    ld_d      = ld_q;
    src_d     = src_q;
    clr_d     = clr_q;
    flush_d   = flush_q;
    wbi_d     = wbi_q;
    wbv_d     = wbv_q;
    last_d    = last_q;

    if (cmd_i.load) begin
      list_d  = reg_list_i;
      lsm_d   = in_lsm;
      load_d  = (op_i == OP_LDMIA) || (op_i == OP_POP);
      first_d = 1'b1;
      bidx_d  = base_index_i;
      addr_d  = base_value_i;
      if (in_lsm) begin
        wb_idx_d = {1'b0, base_index_i};
        // An empty list moves only the PC.
        extra_d  = (reg_list_i == 8'd0);
        final_d  = (reg_list_i == 8'd0) ? base_value_i + EMPTY_STEP
                                        : base_value_i + span;
      end else begin
        wb_idx_d = SP_INDEX;
        extra_d  = with_link_or_pc_i;
        if (op_i == OP_POP) begin
          final_d = base_value_i + span;
        end else begin
          final_d = base_value_i - span;
          addr_d  = base_value_i - span;
        end
      end
    end else if (cmd_i.step) begin
      tv_d      = 1'b1;
      address_d = addr_q;
      ld_d      = load_q;
      src_d     = SRC_REG;
      clr_d     = 1'b0;
      flush_d   = 1'b0;
      priority if (list_q != 8'd0) begin
        reg_d  = {1'b0, low_idx};
        if (lsm_q && !load_q && !first_q && (low_idx == bidx_q)) src_d = SRC_FINAL;
        list_d = list_rest;
      end else if (extra_q) begin
        extra_d = 1'b0;
        if (load_q) begin
          reg_d   = PC_INDEX;
          clr_d   = 1'b1;
          flush_d = 1'b1;
        end else if (lsm_q) begin
          reg_d = PC_INDEX;
          src_d = SRC_PC_PLUS2;
        end else begin
          reg_d = LR_INDEX;
        end
      end else begin
        // Push or pop with nothing to move.
        tv_d      = 1'b0;
        address_d = 32'd0;
        reg_d     = 4'd0;
        ld_d      = 1'b0;
      end
      addr_d  = addr_q + 32'd4;
      first_d = 1'b0;
      last_d  = step_last;
      wbi_d   = step_last ? wb_idx_q : 4'd0;
      wbv_d   = step_last ? final_q : 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q    <= list_d;
    extra_q   <= extra_d;
    lsm_q     <= lsm_d;
    load_q    <= load_d;
    first_q   <= first_d;
    bidx_q    <= bidx_d;
    wb_idx_q  <= wb_idx_d;
    addr_q    <= addr_d;
    final_q   <= final_d;
    tv_q      <= tv_d;
    address_q <= address_d;
    reg_q     <= reg_d;
    ld_q      <= ld_d;
    src_q     <= src_d;
    clr_q     <= clr_d;
    flush_q   <= flush_d;
    wbi_q     <= wbi_d;
    wbv_q     <= wbv_d;
    last_q    <= last_d;
  end

  assign transfer_valid_o  = tv_q;
  assign address_o         = address_q;
  assign reg_index_o       = reg_q;
  assign is_load_o         = ld_q;
  assign store_source_o    = src_q;
  assign clear_low_bit_o   = clr_q;
  assign flush_pipeline_o  = flush_q;
  assign writeback_index_o = wbi_q;
  assign writeback_value_o = wbv_q;
  assign last_o            = last_q;

endmodule

// ===== rtl/thumb_block_transfer_sequencer_unit.sv =====
// Top level of the Thumb block-transfer sequencer (STMIA, LDMIA, PUSH, POP).
// Instantiates tbts_ctrl and tbts_datapath; depends on tbts_pkg.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------
//   in      | input     | in_valid_i / in_ready_o  | op, reg_list, base, link/pc bit
//   out     | output    | out_valid_o / out_ready_i| one memory transfer per result
//
// An instruction is taken while idle, then emits one transfer per cycle while
// the output is not stalled: 1 to 9 results per instruction, set by the
// single shared address/list walker. A stalled output holds the walker; the
// next instruction is accepted as soon as the last transfer is in the output
// register. Reset clears the controller and output valid only.
module thumb_block_transfer_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  reg_list_i,
  input  logic [2:0]  base_index_i,
  input  logic [31:0] base_value_i,
  input  logic        with_link_or_pc_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        transfer_valid_o,
  output logic [31:0] address_o,
  output logic [3:0]  reg_index_o,
  output logic        is_load_o,
  output logic [1:0]  store_source_o,
  output logic        clear_low_bit_o,
  output logic        flush_pipeline_o,
  output logic [3:0]  writeback_index_o,
  output logic [31:0] writeback_value_o,
  output logic        last_o
);
  import tbts_pkg::*;

  cmd_t    cmd;
  status_t status;

  tbts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  tbts_datapath u_datapath (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .op_i              (op_i),
    .reg_list_i        (reg_list_i),
    .base_index_i      (base_index_i),
    .base_value_i      (base_value_i),
    .with_link_or_pc_i (with_link_or_pc_i),
    .transfer_valid_o  (transfer_valid_o),
    .address_o         (address_o),
    .reg_index_o       (reg_index_o),
    .is_load_o         (is_load_o),
    .store_source_o    (store_source_o),
    .clear_low_bit_o   (clear_low_bit_o),
    .flush_pipeline_o  (flush_pipeline_o),
    .writeback_index_o (writeback_index_o),
    .writeback_value_o (writeback_value_o),
    .last_o            (last_o)
  );

endmodule
